>>> hw/rtl/rbdq_pkg.sv
`default_nettype none

package rbdq_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [2:0] {
    CMD_QUERY      = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } rbdq_cmd_t;

  typedef struct packed {
    rbdq_cmd_t                 cmd;
    logic signed [WORD_W-1:0]  push_value;
  } rbdq_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  pop_value;
    logic                      pop_ok;
    logic                      overflow;
    logic [COUNT_W-1:0]        count;
    logic                      deque_empty;
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  back_value;
  } rbdq_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/ring_buffer_deque_core.sv
// Channel    Handshake               Payload
// command    start (busy low)        req : rbdq_req_t
// result     done (one cycle)        rsp : rbdq_rsp_t
//
// A push, a query, an overflowed push, a pop on an empty deque or a pop that
// empties the deque finishes in S_EXEC; any other pop then passes S_READ,
// since the new front or back word comes from the registered read port.
// Busy is high from the cycle after acceptance until the done strobe.
// Synchronous reset empties the deque; the word store itself is not cleared.
// The receiver cannot stall; done marks each result for exactly one cycle, and rsp holds it until the next result.
`default_nettype none

module ring_buffer_deque_core #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire rbdq_pkg::rbdq_req_t req,
  output      logic                busy,
  output      logic                done,
  output      rbdq_pkg::rbdq_rsp_t rsp
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr;
  logic signed [rbdq_pkg::WORD_W-1:0] mem_wdata;
  logic                               mem_re;
  logic [AW-1:0]                      mem_raddr;
  logic signed [rbdq_pkg::WORD_W-1:0] mem_rdata;

  rbdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rbdq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/rbdq_store.sv
`default_nettype none

module rbdq_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [AW-1:0]                     waddr,
  input  wire logic signed [rbdq_pkg::WORD_W-1:0] wdata,
  input  wire logic                              re,
  input  wire logic [AW-1:0]                     raddr,
  output      logic signed [rbdq_pkg::WORD_W-1:0] rdata
);

  logic signed [rbdq_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rbdq_ctrl.sv
`default_nettype none

module rbdq_ctrl #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire rbdq_pkg::rbdq_req_t                req,
  output      logic                               busy,
  output      logic                               done,
  output      rbdq_pkg::rbdq_rsp_t                rsp,
  output      logic                               mem_we,
  output      logic [AW-1:0]                      mem_waddr,
  output      logic signed [rbdq_pkg::WORD_W-1:0] mem_wdata,
  output      logic                               mem_re,
  output      logic [AW-1:0]                      mem_raddr,
  input  wire logic signed [rbdq_pkg::WORD_W-1:0] mem_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t                             state;
  state_t                             state_next;
  rbdq_pkg::rbdq_req_t                req_q;
  logic [AW-1:0]                      head;
  logic [AW-1:0]                      head_next;
  logic [AW-1:0]                      tail;
  logic [AW-1:0]                      tail_next;
  logic [CW-1:0]                      held;
  logic [CW-1:0]                      held_next;
  logic signed [rbdq_pkg::WORD_W-1:0] front_word;
  logic signed [rbdq_pkg::WORD_W-1:0] front_word_next;
  logic signed [rbdq_pkg::WORD_W-1:0] back_word;
  logic signed [rbdq_pkg::WORD_W-1:0] back_word_next;
  logic signed [rbdq_pkg::WORD_W-1:0] popped;
  logic signed [rbdq_pkg::WORD_W-1:0] popped_next;
  logic                               pop_ok;
  logic                               pop_ok_next;
  logic                               ovf;
  logic                               ovf_next;
  logic                               read_front;
  logic                               read_front_next;
  logic                               need_read;
  logic                               is_full;
  logic                               is_none;
  rbdq_pkg::rbdq_rsp_t                rsp_next;

  function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] pos_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  assign is_full = (held == CW'(DEPTH));
  assign is_none = (held == '0);

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    held_next       = held;
    front_word_next = front_word;
    back_word_next  = back_word;
    popped_next     = popped;
    pop_ok_next     = pop_ok;
    ovf_next        = ovf;
    read_front_next = read_front;
    need_read       = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = head;
    mem_wdata       = req_q.push_value;
    mem_re          = 1'b0;
    mem_raddr       = head;

    if (state == S_EXEC) begin
      popped_next = '0;
      pop_ok_next = 1'b0;
      ovf_next    = 1'b0;
      unique case (req_q.cmd)
        rbdq_pkg::CMD_PUSH_FRONT: begin
          if (is_full) begin
            ovf_next = 1'b1;
          end else begin
            head_next       = pos_dec(head);
            mem_we          = 1'b1;
            mem_waddr       = head_next;
            front_word_next = req_q.push_value;
            if (is_none) begin
              back_word_next = req_q.push_value;
            end
            held_next = held + CW'(1);
          end
        end
        rbdq_pkg::CMD_PUSH_BACK: begin
          if (is_full) begin
            ovf_next = 1'b1;
          end else begin
            mem_we         = 1'b1;
            mem_waddr      = tail;
            tail_next      = pos_inc(tail);
            back_word_next = req_q.push_value;
            if (is_none) begin
              front_word_next = req_q.push_value;
            end
            held_next = held + CW'(1);
          end
        end
        rbdq_pkg::CMD_POP_FRONT: begin
          if (!is_none) begin
            popped_next     = front_word;
            pop_ok_next     = 1'b1;
            head_next       = pos_inc(head);
            held_next       = held - CW'(1);
            need_read       = (held != CW'(1));
            read_front_next = 1'b1;
            mem_re          = need_read;
            mem_raddr       = head_next;
          end
        end
        rbdq_pkg::CMD_POP_BACK: begin
          if (!is_none) begin
            popped_next     = back_word;
            pop_ok_next     = 1'b1;
            tail_next       = pos_dec(tail);
            held_next       = held - CW'(1);
            need_read       = (held != CW'(1));
            read_front_next = 1'b0;
            mem_re          = need_read;
            mem_raddr       = pos_dec(tail_next);
          end
        end
        default: begin
        end
      endcase
    end else if (state == S_READ) begin
      if (read_front) begin
        front_word_next = mem_rdata;
      end else begin
        back_word_next = mem_rdata;
      end
    end
  end

  always_comb begin
    rsp_next.pop_value   = popped_next;
    rsp_next.pop_ok      = pop_ok_next;
    rsp_next.overflow    = ovf_next;
    rsp_next.count       = rbdq_pkg::COUNT_W'(held_next);
    rsp_next.deque_empty = (held_next == '0);
    rsp_next.front_value = (held_next == '0) ? '0 : front_word_next;
    rsp_next.back_value  = (held_next == '0) ? '0 : back_word_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = need_read ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      head  <= '0;
      tail  <= '0;
      held  <= '0;
    end else begin
      state      <= state_next;
      busy       <= (state_next != S_IDLE);
      done       <= (state != S_IDLE) && (state_next == S_IDLE);
      head       <= head_next;
      tail       <= tail_next;
      held       <= held_next;
      front_word <= front_word_next;
      back_word  <= back_word_next;
      popped     <= popped_next;
      pop_ok     <= pop_ok_next;
      ovf        <= ovf_next;
      read_front <= read_front_next;
      if (state == S_IDLE && start) begin
        req_q <= req;
      end
      if (state_next == S_IDLE && state != S_IDLE) begin
        rsp <= rsp_next;
      end
    end
  end

endmodule

`default_nettype wire
